### rtl/two_channel_button_pwm_dimmer_unit_assert.svh
// assertion macros for the two-channel button pwm dimmer
// used by modules that include this header; needs clk and rst_n in scope
`ifndef TWO_CHANNEL_BUTTON_PWM_DIMMER_UNIT_ASSERT_SVH
`define TWO_CHANNEL_BUTTON_PWM_DIMMER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCBPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCBPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tcbpd_pkg.sv
// package for the two-channel button pwm dimmer
// shared constants, codes and types; no dependencies
package tcbpd_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int NUM_BUTTONS  = 3 * NUM_CHANNELS;
  localparam int OUT_CHANNELS = 2;

  localparam int LOCK_W   = 16;
  localparam int PERIOD_W = 8;
  localparam int STEP_W   = 8;
  localparam int LEVEL_W  = 4;
  localparam int BTN_W    = 3;
  localparam int CFG_W    = 16;
  localparam int LIMIT_W  = LEVEL_W + STEP_W;

  localparam logic [LOCK_W-1:0]   RST_LOCKOUT = LOCK_W'(2000);
  localparam logic [PERIOD_W-1:0] RST_PERIOD  = PERIOD_W'(100);
  localparam logic [STEP_W-1:0]   RST_STEP    = STEP_W'(12);
  localparam logic [LEVEL_W-1:0]  RST_MAX     = LEVEL_W'(8);

  typedef enum logic [1:0] {
    CFG_LOCKOUT = 2'd0,
    CFG_PERIOD  = 2'd1,
    CFG_STEP    = 2'd2,
    CFG_MAX     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_PRESS = 1'b1
  } func_t;

  // button offset within a channel's group of three
  localparam int KIND_TOGGLE = 0;
  localparam int KIND_DIM    = 1;
  localparam int KIND_BRIGHT = 2;

  typedef struct packed {
    logic toggle;
    logic dim;
    logic bright;
  } chan_evt_t;

endpackage

### rtl/tcbpd_chan.sv
// one dimmer channel: on/off and brightness state plus pwm compare
// depends on tcbpd_pkg
module tcbpd_chan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcbpd_pkg::chan_evt_t           evt,
  input  logic [tcbpd_pkg::STEP_W-1:0]   duty_step,
  input  logic [tcbpd_pkg::LEVEL_W-1:0]  max_level,
  input  logic [tcbpd_pkg::PERIOD_W-1:0] pwm_nxt,
  output logic                           on_nxt,
  output logic [tcbpd_pkg::LEVEL_W-1:0]  level_nxt,
  output logic                           drive_nxt
);

  logic                          on_r;
  logic [tcbpd_pkg::LEVEL_W-1:0] level_r;
  logic [tcbpd_pkg::LIMIT_W-1:0] limit;

  always_comb begin
    on_nxt    = on_r;
    level_nxt = level_r;
    if (evt.toggle) begin
      on_nxt = !on_r;
    end
    if (evt.dim && (level_r != '0)) begin
      level_nxt = level_r - tcbpd_pkg::LEVEL_W'(1);
    end
    if (evt.bright && (level_r < max_level)) begin
      level_nxt = level_r + tcbpd_pkg::LEVEL_W'(1);
    end
  end

  // high time in ticks for the new level
  assign limit     = tcbpd_pkg::LIMIT_W'(level_nxt) * tcbpd_pkg::LIMIT_W'(duty_step);
  assign drive_nxt = on_nxt && (tcbpd_pkg::LIMIT_W'(pwm_nxt) < limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b1;
      level_r <= tcbpd_pkg::RST_MAX;
    end else begin
      on_r    <= on_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

### rtl/two_channel_button_pwm_dimmer_unit.sv
// path: an accepted request passes the input register, then the result register;
// throughput: one request per cycle while results are taken; a stalled result holds
// one request in the input register and then blocks the input.
// reset (synchronous, rst_n low): config registers take their defaults, lockout and
// pwm counters clear, both channels come up on at level 8, no result pending.
// top level of the two-channel button pwm dimmer; depends on tcbpd_pkg and tcbpd_chan
module two_channel_button_pwm_dimmer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [tcbpd_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [tcbpd_pkg::BTN_W-1:0]       in_button,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_led0_drive,
  output logic                              out_led1_drive,
  output logic                              out_led0_enabled,
  output logic                              out_led1_enabled,
  output logic [tcbpd_pkg::LEVEL_W-1:0]     out_led0_level,
  output logic [tcbpd_pkg::LEVEL_W-1:0]     out_led1_level,
  output logic                              out_press_accepted
);

  localparam int NB = tcbpd_pkg::NUM_BUTTONS;
  localparam int NC = tcbpd_pkg::NUM_CHANNELS;
  localparam int OC = tcbpd_pkg::OUT_CHANNELS;

  // configuration
  logic [tcbpd_pkg::LOCK_W-1:0]   lockout_ticks_r;
  logic [tcbpd_pkg::PERIOD_W-1:0] pwm_period_r;
  logic [tcbpd_pkg::STEP_W-1:0]   duty_step_r;
  logic [tcbpd_pkg::LEVEL_W-1:0]  max_level_r;

  // input register
  logic                         in_v_r;
  logic                         in_func_r;
  logic [tcbpd_pkg::BTN_W-1:0]  in_button_r;

  // state
  logic [tcbpd_pkg::LOCK_W-1:0]   lockout_r   [NB];
  logic [tcbpd_pkg::LOCK_W-1:0]   lockout_nxt [NB];
  logic [tcbpd_pkg::PERIOD_W-1:0] pwm_r;
  logic [tcbpd_pkg::PERIOD_W-1:0] pwm_nxt;
  logic [tcbpd_pkg::PERIOD_W:0]   pwm_inc;

  // result register
  logic                           out_v_r;
  logic [OC-1:0]                  out_drive_r;
  logic [OC-1:0]                  out_on_r;
  logic [tcbpd_pkg::LEVEL_W-1:0]  out_level_r [OC];
  logic                           out_acc_r;

  logic                           step_en;
  logic                           is_tick;
  logic                           is_press;
  logic [NB-1:0]                  hit;
  logic                           acc_nxt;

  logic [NC-1:0]                  ch_on;
  logic [NC-1:0]                  ch_drive;
  logic [tcbpd_pkg::LEVEL_W-1:0]  ch_level [NC];
  logic [OC-1:0]                  pad_on;
  logic [OC-1:0]                  pad_drive;
  logic [tcbpd_pkg::LEVEL_W-1:0]  pad_level [OC];

  assign step_en  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step_en;
  assign is_tick  = step_en && (in_func_r == tcbpd_pkg::FUNC_TICK);
  assign is_press = step_en && (in_func_r == tcbpd_pkg::FUNC_PRESS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_ticks_r <= tcbpd_pkg::RST_LOCKOUT;
      pwm_period_r    <= tcbpd_pkg::RST_PERIOD;
      duty_step_r     <= tcbpd_pkg::RST_STEP;
      max_level_r     <= tcbpd_pkg::RST_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        tcbpd_pkg::CFG_LOCKOUT: lockout_ticks_r <= cfg_wdata;
        tcbpd_pkg::CFG_PERIOD:  pwm_period_r    <= cfg_wdata[tcbpd_pkg::PERIOD_W-1:0];
        tcbpd_pkg::CFG_STEP:    duty_step_r     <= cfg_wdata[tcbpd_pkg::STEP_W-1:0];
        tcbpd_pkg::CFG_MAX:     max_level_r     <= cfg_wdata[tcbpd_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (step_en) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_func_r   <= in_func;
      in_button_r <= in_button;
    end
  end

  // lockout: a press passes only on a zero counter and reloads it
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      hit[i]         = is_press && (in_button_r == tcbpd_pkg::BTN_W'(i))
                       && (lockout_r[i] == '0);
      lockout_nxt[i] = lockout_r[i];
      if (hit[i]) begin
        lockout_nxt[i] = lockout_ticks_r;
      end else if (is_tick && (lockout_r[i] != '0)) begin
        lockout_nxt[i] = lockout_r[i] - tcbpd_pkg::LOCK_W'(1);
      end
    end
  end

  assign acc_nxt = |hit;

  // shared pwm counter, wraps on reaching the period
  assign pwm_inc = {1'b0, pwm_r} + (tcbpd_pkg::PERIOD_W + 1)'(1);
  always_comb begin
    pwm_nxt = pwm_r;
    if (is_tick) begin
      if (pwm_inc >= {1'b0, pwm_period_r}) begin
        pwm_nxt = '0;
      end else begin
        pwm_nxt = pwm_inc[tcbpd_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_r <= '0;
      for (int i = 0; i < NB; i++) begin
        lockout_r[i] <= '0;
      end
    end else begin
      pwm_r <= pwm_nxt;
      for (int i = 0; i < NB; i++) begin
        lockout_r[i] <= lockout_nxt[i];
      end
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_chan
    tcbpd_pkg::chan_evt_t evt;
    assign evt.toggle = hit[3*c + tcbpd_pkg::KIND_TOGGLE];
    assign evt.dim    = hit[3*c + tcbpd_pkg::KIND_DIM];
    assign evt.bright = hit[3*c + tcbpd_pkg::KIND_BRIGHT];

    tcbpd_chan u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .evt       (evt),
      .duty_step (duty_step_r),
      .max_level (max_level_r),
      .pwm_nxt   (pwm_nxt),
      .on_nxt    (ch_on[c]),
      .level_nxt (ch_level[c]),
      .drive_nxt (ch_drive[c])
    );
  end

  // result fields of channels that are not built read as zero
  for (genvar k = 0; k < OC; k++) begin : g_pad
    if (k < NC) begin : g_real
      assign pad_on[k]    = ch_on[k];
      assign pad_drive[k] = ch_drive[k];
      assign pad_level[k] = ch_level[k];
    end else begin : g_none
      assign pad_on[k]    = 1'b0;
      assign pad_drive[k] = 1'b0;
      assign pad_level[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_drive_r <= pad_drive;
      out_on_r    <= pad_on;
      out_acc_r   <= acc_nxt;
      for (int k = 0; k < OC; k++) begin
        out_level_r[k] <= pad_level[k];
      end
    end
  end

  assign out_valid          = out_v_r;
  assign out_led0_drive     = out_drive_r[0];
  assign out_led1_drive     = out_drive_r[1];
  assign out_led0_enabled   = out_on_r[0];
  assign out_led1_enabled   = out_on_r[1];
  assign out_led0_level     = out_level_r[0];
  assign out_led1_level     = out_level_r[1];
  assign out_press_accepted = out_acc_r;

`include "two_channel_button_pwm_dimmer_unit_assert.svh"

  `TCBPD_ASSERT_SAME(a_one_hit, 1'b1, $onehot0(hit), "more than one button passed lockout")
  `TCBPD_ASSERT_SAME(a_tick_no_hit, is_tick, hit == '0, "press accepted on a tick")
  `TCBPD_ASSERT_NEXT(a_acc_flag, step_en && acc_nxt, out_valid && out_press_accepted,
                     "accepted press not flagged in result")
  `TCBPD_ASSERT_NEXT(a_press_pwm_hold, is_press, $stable(pwm_r), "pwm counter moved on a press")
  `TCBPD_ASSERT_NEXT(a_in_hold, in_v_r && !step_en, in_v_r && $stable(in_button_r),
                     "pending request lost while result stalled")

endmodule

### bench/tb_two_channel_button_pwm_dimmer_unit.sv
`timescale 1ns / 100ps
// testbench for two_channel_button_pwm_dimmer_unit: directed and random tick and press
// requests, each result checked against a built-in model of lockout, levels and pwm drive
// depends on tcbpd_pkg and the dimmer rtl
module tb_two_channel_button_pwm_dimmer_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int REQS_PER_PHASE = 150;

  typedef struct packed {
    logic                          led0_drive;
    logic                          led1_drive;
    logic                          led0_enabled;
    logic                          led1_enabled;
    logic [tcbpd_pkg::LEVEL_W-1:0] led0_level;
    logic [tcbpd_pkg::LEVEL_W-1:0] led1_level;
    logic                          press_accepted;
  } led_state_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [1:0]                    cfg_index = 2'd0;
  logic [tcbpd_pkg::CFG_W-1:0]   cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_func = 1'b0;
  logic [tcbpd_pkg::BTN_W-1:0]   in_button = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_led0_drive;
  logic                          out_led1_drive;
  logic                          out_led0_enabled;
  logic                          out_led1_enabled;
  logic [tcbpd_pkg::LEVEL_W-1:0] out_led0_level;
  logic [tcbpd_pkg::LEVEL_W-1:0] out_led1_level;
  logic                          out_press_accepted;

  // model state and its copy of the registers
  logic [tcbpd_pkg::LOCK_W-1:0]   lock_left [tcbpd_pkg::NUM_BUTTONS];
  logic                           chan_on [tcbpd_pkg::NUM_CHANNELS];
  logic [tcbpd_pkg::LEVEL_W-1:0]  chan_lvl [tcbpd_pkg::NUM_CHANNELS];
  logic [tcbpd_pkg::PERIOD_W-1:0] pwm_pos;
  logic [tcbpd_pkg::LOCK_W-1:0]   lockout_reload;
  logic [tcbpd_pkg::PERIOD_W-1:0] pwm_wrap;
  logic [tcbpd_pkg::STEP_W-1:0]   lvl_step;
  logic [tcbpd_pkg::LEVEL_W-1:0]  lvl_ceiling;

  led_state_t expected_leds[$];
  int         errors = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  two_channel_button_pwm_dimmer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_button          (in_button),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_led0_drive     (out_led0_drive),
    .out_led1_drive     (out_led1_drive),
    .out_led0_enabled   (out_led0_enabled),
    .out_led1_enabled   (out_led1_enabled),
    .out_led0_level     (out_led0_level),
    .out_led1_level     (out_led1_level),
    .out_press_accepted (out_press_accepted)
  );

  always #5 clk = ~clk;

  function automatic void reset_dimmer_model();
    lockout_reload = tcbpd_pkg::RST_LOCKOUT;
    pwm_wrap       = tcbpd_pkg::RST_PERIOD;
    lvl_step       = tcbpd_pkg::RST_STEP;
    lvl_ceiling    = tcbpd_pkg::RST_MAX;
    foreach (lock_left[i]) lock_left[i] = '0;
    foreach (chan_on[i]) begin
      chan_on[i]  = 1'b1;
      chan_lvl[i] = tcbpd_pkg::RST_MAX;
    end
    pwm_pos = '0;
  endfunction

  function automatic logic pwm_drive(int ch);
    return chan_on[ch] && (tcbpd_pkg::LIMIT_W'(pwm_pos) <
           tcbpd_pkg::LIMIT_W'(chan_lvl[ch]) * tcbpd_pkg::LIMIT_W'(lvl_step));
  endfunction

  function automatic led_state_t dimmer_step(tcbpd_pkg::func_t fn,
                                             logic [tcbpd_pkg::BTN_W-1:0] btn);
    led_state_t                   r;
    logic [tcbpd_pkg::PERIOD_W:0] nxt;
    int                           ch;
    int                           kind;
    r = '0;
    if (fn == tcbpd_pkg::FUNC_TICK) begin
      foreach (lock_left[i]) if (lock_left[i] != 0) lock_left[i]--;
      nxt = {1'b0, pwm_pos} + (tcbpd_pkg::PERIOD_W + 1)'(1);
      pwm_pos = (nxt >= {1'b0, pwm_wrap}) ? '0 : nxt[tcbpd_pkg::PERIOD_W-1:0];
    end else if (btn < tcbpd_pkg::NUM_BUTTONS && lock_left[btn] == 0) begin
      lock_left[btn] = lockout_reload;
      ch   = btn / 3;
      kind = btn % 3;
      r.press_accepted = 1'b1;
      case (kind)
        tcbpd_pkg::KIND_TOGGLE: chan_on[ch] = !chan_on[ch];
        tcbpd_pkg::KIND_DIM: if (chan_lvl[ch] != 0) chan_lvl[ch]--;
        default: if (chan_lvl[ch] < lvl_ceiling) chan_lvl[ch]++;
      endcase
    end
    r.led0_drive   = pwm_drive(0);
    r.led1_drive   = pwm_drive(1);
    r.led0_enabled = chan_on[0];
    r.led1_enabled = chan_on[1];
    r.led0_level   = chan_lvl[0];
    r.led1_level   = chan_lvl[1];
    return r;
  endfunction

  // upper data bits beyond a narrow register get random junk, which must be ignored
  task automatic write_reg(tcbpd_pkg::cfg_idx_t idx, logic [tcbpd_pkg::CFG_W-1:0] value);
    logic [tcbpd_pkg::CFG_W-1:0] data;
    data = value;
    case (idx)
      tcbpd_pkg::CFG_LOCKOUT: lockout_reload = value;
      tcbpd_pkg::CFG_PERIOD: begin
        data[tcbpd_pkg::CFG_W-1:tcbpd_pkg::PERIOD_W] =
          (tcbpd_pkg::CFG_W - tcbpd_pkg::PERIOD_W)'($urandom);
        pwm_wrap = value[tcbpd_pkg::PERIOD_W-1:0];
      end
      tcbpd_pkg::CFG_STEP: begin
        data[tcbpd_pkg::CFG_W-1:tcbpd_pkg::STEP_W] =
          (tcbpd_pkg::CFG_W - tcbpd_pkg::STEP_W)'($urandom);
        lvl_step = value[tcbpd_pkg::STEP_W-1:0];
      end
      default: begin
        data[tcbpd_pkg::CFG_W-1:tcbpd_pkg::LEVEL_W] =
          (tcbpd_pkg::CFG_W - tcbpd_pkg::LEVEL_W)'($urandom);
        lvl_ceiling = value[tcbpd_pkg::LEVEL_W-1:0];
      end
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dimmer(logic [tcbpd_pkg::CFG_W-1:0] lockout,
                            logic [tcbpd_pkg::CFG_W-1:0] period,
                            logic [tcbpd_pkg::CFG_W-1:0] step,
                            logic [tcbpd_pkg::CFG_W-1:0] top_level);
    write_reg(tcbpd_pkg::CFG_LOCKOUT, lockout);
    write_reg(tcbpd_pkg::CFG_PERIOD, period);
    write_reg(tcbpd_pkg::CFG_STEP, step);
    write_reg(tcbpd_pkg::CFG_MAX, top_level);
  endtask

  task automatic send_req(tcbpd_pkg::func_t fn, logic [tcbpd_pkg::BTN_W-1:0] btn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= fn;
    in_button <= btn;
    do @(posedge clk); while (!in_ready);
    expected_leds.push_back(dimmer_step(fn, btn));
  endtask

  // drain all results, then give the two-stage pipe time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_req(tcbpd_pkg::FUNC_TICK, 3'd7);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd6);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd7);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd4);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd0);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd0);
    // default lockout: the button stays blocked across a run of ticks
    repeat (20) send_req(tcbpd_pkg::FUNC_TICK, tcbpd_pkg::BTN_W'($urandom_range(7)));
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd0);
    send_req(tcbpd_pkg::FUNC_TICK, 3'd2);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd0);
  endtask

  task automatic test_level_limits();
    wait_idle();
    // pwm counter sits above the new period, so the next tick wraps it
    set_dimmer(0, 1, 12, 8);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd2);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd2);
    wait_idle();
    write_reg(tcbpd_pkg::CFG_MAX, 3);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd5);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd1);
    send_req(tcbpd_pkg::FUNC_TICK, 3'd3);
    send_req(tcbpd_pkg::FUNC_TICK, 3'd5);
  endtask

  task automatic test_zero_settings();
    wait_idle();
    set_dimmer(5, 0, 8'hFF, 0);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd2);
    send_req(tcbpd_pkg::FUNC_TICK, 3'd1);
    send_req(tcbpd_pkg::FUNC_TICK, 3'd6);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd3);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd3);
    send_req(tcbpd_pkg::FUNC_PRESS, 3'd1);
  endtask

  task automatic test_random_traffic();
    int r;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_dimmer(0, 7, 1, 15);
        1: set_dimmer(3, 20, 2, 5);
        2: set_dimmer(1, 255, 255, 15);
        5: set_dimmer(2, 0, 0, 0);
        7: set_dimmer(16'hFFFF, 1, 255, 1);
        default: set_dimmer(tcbpd_pkg::CFG_W'($urandom_range(6)),
                            tcbpd_pkg::CFG_W'($urandom_range(40)),
                            tcbpd_pkg::CFG_W'($urandom_range(12)),
                            tcbpd_pkg::CFG_W'($urandom_range(15)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      repeat (REQS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 45) begin
          send_req(tcbpd_pkg::FUNC_TICK, tcbpd_pkg::BTN_W'($urandom_range(7)));
        end else if (r < 93) begin
          send_req(tcbpd_pkg::FUNC_PRESS, tcbpd_pkg::BTN_W'($urandom_range(5)));
        end else begin
          send_req(tcbpd_pkg::FUNC_PRESS, tcbpd_pkg::BTN_W'($urandom_range(7, 6)));
        end
      end
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic report_field(string name, logic [tcbpd_pkg::LEVEL_W-1:0] want,
                              logic [tcbpd_pkg::LEVEL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    led_state_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_leds.size() == 0) begin
          $display("%0t: result with no request pending", $time);
          errors++;
        end else begin
          want = expected_leds.pop_front();
          report_field("led0_drive", tcbpd_pkg::LEVEL_W'(want.led0_drive),
                       tcbpd_pkg::LEVEL_W'(out_led0_drive));
          report_field("led1_drive", tcbpd_pkg::LEVEL_W'(want.led1_drive),
                       tcbpd_pkg::LEVEL_W'(out_led1_drive));
          report_field("led0_enabled", tcbpd_pkg::LEVEL_W'(want.led0_enabled),
                       tcbpd_pkg::LEVEL_W'(out_led0_enabled));
          report_field("led1_enabled", tcbpd_pkg::LEVEL_W'(want.led1_enabled),
                       tcbpd_pkg::LEVEL_W'(out_led1_enabled));
          report_field("led0_level", want.led0_level, out_led0_level);
          report_field("led1_level", want.led1_level, out_led1_level);
          report_field("press_accepted", tcbpd_pkg::LEVEL_W'(want.press_accepted),
                       tcbpd_pkg::LEVEL_W'(out_press_accepted));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    reset_dimmer_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_level_limits();
    test_zero_settings();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tcbpd_pkg.sv
rtl/tcbpd_chan.sv
rtl/two_channel_button_pwm_dimmer_unit.sv
bench/tb_two_channel_button_pwm_dimmer_unit.sv
